// ===== hw/rtl/gls_pkg.sv =====
// shared types and constants for the grid laplacian stencil block
package gls_pkg;

    localparam int IDX_W           = 12;
    localparam int DATA_W          = 32;
    localparam int SIZE_W          = 13;
    localparam int DIMS_W          = 2;
    localparam int CFG_IDX_W       = 3;
    localparam int DEF_MAX_POINTS  = 4096;
    // neighbour address: index plus a stride of up to size_x * size_y
    localparam int NB_W            = 2 * SIZE_W + 1;
    // 2v minus two neighbours
    localparam int D_W             = DATA_W + 3;
    localparam int M_W             = 17;
    localparam int P_W             = D_W + M_W;
    localparam int ACC_W           = P_W + 4;
    localparam int HALF_W          = 16;

    typedef enum logic {
        OP_STORE   = 1'b0,
        OP_COMPUTE = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIMENSIONS = 3'd0,
        CFG_SIZE_X     = 3'd1,
        CFG_SIZE_Y     = 3'd2,
        CFG_SIZE_Z     = 3'd3,
        CFG_COEF_X     = 3'd4,
        CFG_COEF_Y     = 3'd5,
        CFG_COEF_Z     = 3'd6
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIVX,
        S_DIVY,
        S_STRIDE,
        S_READV,
        S_VPHI,
        S_VPLO,
        S_NBRD,
        S_NBSUB,
        S_THI,
        S_TLO,
        S_ACCW,
        S_FIN
    } state_t;

endpackage

// ===== hw/rtl/gls_ram.sv =====
// generic single-port ram with registered read
module gls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/grid_laplacian_stencil_matvec.sv =====
// top level: hamiltonian stencil operator on a 1-, 2- or 3-d grid
//
// Usage: a store beat (operation 0) writes element and potential_term at
// index and busy stays low, so another beat may follow at once.
// A compute beat (operation 1) raises busy unless its index or a size is
// bad; one result beat appears later with done high for exactly one cycle,
// carrying result_index, the saturated Q16.16 result_value and the
// saturated and bad_index flags. An index at or beyond the store depth,
// or a zero size, gives its result in the next cycle; an index beyond the
// grid is found after both splits. A valid index passes the restoring
// divider (one split by size_x, one by size_y), then stride, center read
// and the potential product, then for each active axis two neighbour
// reads through the single ram port and two passes of the shared 35x17
// multiplier, then accumulation and rounding, and then the result beat.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once;
// the user is to make them only while the block is idle, which the block
// itself does not enforce. Reset restores dimensions 1, sizes 1 and zero
// coefficients; the stores are not cleared. The receiver cannot stall:
// done is a one cycle strobe.
module grid_laplacian_stencil_matvec #(
    parameter int MAX_POINTS = gls_pkg::DEF_MAX_POINTS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          operation,
    input  logic [gls_pkg::IDX_W-1:0]     index,
    input  logic signed [gls_pkg::DATA_W-1:0] element,
    input  logic signed [gls_pkg::DATA_W-1:0] potential_term,
    input  logic                          cfg_we,
    input  logic [gls_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gls_pkg::DATA_W-1:0]    cfg_data,
    output logic                          done,
    output logic [gls_pkg::IDX_W-1:0]     result_index,
    output logic signed [gls_pkg::DATA_W-1:0] result_value,
    output logic                          saturated,
    output logic                          bad_index
);

    import gls_pkg::*;

    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam logic [IDX_W-1:0] DIV_LAST = IDX_W'(IDX_W - 1);

    state_t state_reg, state_next;

    logic [DIMS_W-1:0] dims_reg;
    logic [SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [DATA_W-1:0] coef_x_reg, coef_y_reg, coef_z_reg;

    logic [IDX_W-1:0]  i_reg;
    logic [IDX_W-1:0]  div_cnt_reg;
    logic [IDX_W-1:0]  quo_reg;
    logic [SIZE_W-1:0] rem_reg;
    logic [IDX_W-1:0]  xpos_reg;
    logic [NB_W-1:0]   stride_xy_reg;
    logic signed [DATA_W-1:0] v_reg;
    logic [DATA_W-1:0] p_reg;
    logic signed [D_W-1:0] d_reg;
    logic [1:0]        axis_reg;
    logic              nb_sel_reg;
    logic              nb_ok_reg;
    logic signed [P_W-1:0] prod_reg;
    logic              acc_a_reg, acc_b_reg;
    logic signed [ACC_W-1:0] a_reg, b_reg;

    logic              done_reg, sat_reg, bad_reg;
    logic [IDX_W-1:0]  res_idx_reg;
    logic signed [DATA_W-1:0] res_val_reg;

    // ram side
    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [DATA_W-1:0] vram_q, pram_q;

    // divider step
    logic [SIZE_W:0]   trial;
    logic              trial_ge;
    logic [SIZE_W-1:0] divisor;
    logic [SIZE_W-1:0] rem_step;
    logic [IDX_W-1:0]  quo_step;

    // per-axis selection
    logic [1:0]        last_axis;
    logic [IDX_W-1:0]  pos_cur;
    logic [SIZE_W-1:0] size_cur;
    logic [NB_W-1:0]   stride_cur;
    logic [DATA_W-1:0] coef_cur;
    logic [NB_W-1:0]   i_ext, index_ext, nb_addr;
    logic              nb_cond, nb_ok;
    logic              early_bad;

    logic signed [D_W-1:0] mul_a;
    logic signed [M_W-1:0] mul_b;
    logic                  acc_a_next, acc_b_next;

    logic signed [ACC_W-1:0] b_round, r_sum;
    logic                    r_hi, r_lo;

    assign index_ext = NB_W'(index);
    assign i_ext     = NB_W'(i_reg);
    assign early_bad = (index_ext >= NB_W'(MAX_POINTS)) || (size_x_reg == '0)
                       || (size_y_reg == '0) || (size_z_reg == '0);
    assign last_axis = (dims_reg == '0) ? 2'd0 : dims_reg - 2'd1;

    // restoring division, one quotient bit a cycle
    assign divisor  = (state_reg == S_DIVY) ? size_y_reg : size_x_reg;
    assign trial    = {rem_reg, quo_reg[IDX_W-1]};
    assign trial_ge = trial >= {1'b0, divisor};
    assign rem_step = trial_ge ? SIZE_W'(trial - {1'b0, divisor}) : trial[SIZE_W-1:0];
    assign quo_step = {quo_reg[IDX_W-2:0], trial_ge};

    always_comb
    begin
        case (axis_reg)
            2'd1:
            begin
                pos_cur    = rem_reg[IDX_W-1:0];
                size_cur   = size_y_reg;
                stride_cur = NB_W'(size_x_reg);
                coef_cur   = coef_y_reg;
            end
            2'd2:
            begin
                pos_cur    = quo_reg;
                size_cur   = size_z_reg;
                stride_cur = stride_xy_reg;
                coef_cur   = coef_z_reg;
            end
            default:
            begin
                pos_cur    = xpos_reg;
                size_cur   = size_x_reg;
                stride_cur = NB_W'(1);
                coef_cur   = coef_x_reg;
            end
        endcase
    end

    assign nb_addr = nb_sel_reg ? i_ext + stride_cur : i_ext - stride_cur;
    assign nb_cond = nb_sel_reg ? ((SIZE_W'(pos_cur) + SIZE_W'(1)) < size_cur)
                                : (pos_cur != '0);
    assign nb_ok   = nb_cond && (nb_addr < NB_W'(MAX_POINTS));

    // next state, ram control and multiplier operands
    always_comb
    begin
        state_next = state_reg;
        ram_we     = 1'b0;
        ram_addr   = index_ext[ADDR_W-1:0];
        mul_a      = '0;
        mul_b      = '0;
        acc_a_next = 1'b0;
        acc_b_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start && operation == OP_STORE)
                begin
                    ram_we = index_ext < NB_W'(MAX_POINTS);
                end
                else if (start && !early_bad)
                begin
                    state_next = S_DIVX;
                end
            end
            S_DIVX:
            begin
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = S_DIVY;
                end
            end
            S_DIVY:
            begin
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = S_STRIDE;
                end
            end
            S_STRIDE:
            begin
                mul_a      = D_W'(size_x_reg);
                mul_b      = M_W'(size_y_reg);
                state_next = (SIZE_W'(quo_reg) >= size_z_reg) ? S_IDLE : S_READV;
            end
            S_READV:
            begin
                ram_addr   = i_ext[ADDR_W-1:0];
                state_next = S_VPHI;
            end
            S_VPHI:
            begin
                mul_a      = D_W'($signed(vram_q));
                mul_b      = M_W'($signed(pram_q[DATA_W-1:HALF_W]));
                acc_a_next = 1'b1;
                state_next = S_VPLO;
            end
            S_VPLO:
            begin
                mul_a      = D_W'(v_reg);
                mul_b      = {1'b0, p_reg[HALF_W-1:0]};
                acc_b_next = 1'b1;
                state_next = S_NBRD;
            end
            S_NBRD:
            begin
                ram_addr   = nb_addr[ADDR_W-1:0];
                state_next = S_NBSUB;
            end
            S_NBSUB:
            begin
                state_next = nb_sel_reg ? S_THI : S_NBRD;
            end
            S_THI:
            begin
                mul_a      = d_reg;
                mul_b      = {1'b0, coef_cur[DATA_W-1:HALF_W]};
                acc_a_next = 1'b1;
                state_next = S_TLO;
            end
            S_TLO:
            begin
                mul_a      = d_reg;
                mul_b      = {1'b0, coef_cur[HALF_W-1:0]};
                acc_b_next = 1'b1;
                state_next = (axis_reg == last_axis) ? S_ACCW : S_NBRD;
            end
            S_ACCW:
            begin
                state_next = S_FIN;
            end
            S_FIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // round b to Q16.16 with ties up, add a, then saturate
    assign b_round = (b_reg + ACC_W'(32768)) >>> HALF_W;
    assign r_sum   = a_reg + b_round;
    assign r_hi    = r_sum > ACC_W'(32'sh7FFF_FFFF);
    assign r_lo    = r_sum < -ACC_W'(33'sh0_8000_0000);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            dims_reg   <= DIMS_W'(1);
            size_x_reg <= SIZE_W'(1);
            size_y_reg <= SIZE_W'(1);
            size_z_reg <= SIZE_W'(1);
            coef_x_reg <= '0;
            coef_y_reg <= '0;
            coef_z_reg <= '0;
            done_reg   <= 1'b0;
            acc_a_reg  <= 1'b0;
            acc_b_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            acc_a_reg <= acc_a_next;
            acc_b_reg <= acc_b_next;
            done_reg  <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_DIMENSIONS: dims_reg   <= cfg_data[DIMS_W-1:0];
                    CFG_SIZE_X:     size_x_reg <= cfg_data[SIZE_W-1:0];
                    CFG_SIZE_Y:     size_y_reg <= cfg_data[SIZE_W-1:0];
                    CFG_SIZE_Z:     size_z_reg <= cfg_data[SIZE_W-1:0];
                    CFG_COEF_X:     coef_x_reg <= cfg_data;
                    CFG_COEF_Y:     coef_y_reg <= cfg_data;
                    CFG_COEF_Z:     coef_z_reg <= cfg_data;
                    default:        ;
                endcase
            end
            if (state_reg == S_IDLE && start && operation == OP_COMPUTE && early_bad)
            begin
                done_reg <= 1'b1;
            end
            if (state_reg == S_STRIDE && SIZE_W'(quo_reg) >= size_z_reg)
            begin
                done_reg <= 1'b1;
            end
            if (state_reg == S_FIN)
            begin
                done_reg <= 1'b1;
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (acc_a_reg)
        begin
            a_reg <= a_reg + ACC_W'(prod_reg);
        end
        if (acc_b_reg)
        begin
            b_reg <= b_reg + ACC_W'(prod_reg);
        end
        case (state_reg)
            S_IDLE:
            begin
                i_reg       <= index;
                quo_reg     <= index;
                rem_reg     <= '0;
                div_cnt_reg <= '0;
                res_idx_reg <= index;
                res_val_reg <= '0;
                sat_reg     <= 1'b0;
                bad_reg     <= 1'b1;
            end
            S_DIVX:
            begin
                div_cnt_reg <= div_cnt_reg + IDX_W'(1);
                if (div_cnt_reg == DIV_LAST)
                begin
                    // quotient becomes the dividend of the y split
                    xpos_reg    <= rem_step[IDX_W-1:0];
                    quo_reg     <= quo_step;
                    rem_reg     <= '0;
                    div_cnt_reg <= '0;
                end
                else
                begin
                    quo_reg <= quo_step;
                    rem_reg <= rem_step;
                end
            end
            S_DIVY:
            begin
                div_cnt_reg <= div_cnt_reg + IDX_W'(1);
                quo_reg     <= quo_step;
                rem_reg     <= rem_step;
            end
            S_READV:
            begin
                stride_xy_reg <= prod_reg[NB_W-1:0];
                a_reg         <= '0;
                b_reg         <= '0;
                axis_reg      <= 2'd0;
                nb_sel_reg    <= 1'b0;
            end
            S_VPHI:
            begin
                v_reg <= $signed(vram_q);
                p_reg <= pram_q;
            end
            S_VPLO:
            begin
                d_reg <= D_W'(v_reg) <<< 1;
            end
            S_NBRD:
            begin
                nb_ok_reg <= nb_ok;
            end
            S_NBSUB:
            begin
                if (nb_ok_reg)
                begin
                    d_reg <= d_reg - D_W'($signed(vram_q));
                end
                nb_sel_reg <= !nb_sel_reg;
            end
            S_TLO:
            begin
                d_reg    <= D_W'(v_reg) <<< 1;
                axis_reg <= axis_reg + 2'd1;
            end
            S_FIN:
            begin
                bad_reg <= 1'b0;
                sat_reg <= r_hi || r_lo;
                if (r_hi)
                begin
                    res_val_reg <= 32'sh7FFF_FFFF;
                end
                else if (r_lo)
                begin
                    res_val_reg <= 32'sh8000_0000;
                end
                else
                begin
                    res_val_reg <= r_sum[DATA_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    gls_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_POINTS)
    ) u_vec_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (element),
        .rdata (vram_q)
    );

    gls_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_POINTS)
    ) u_pot_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (potential_term),
        .rdata (pram_q)
    );

    assign busy         = state_reg != S_IDLE;
    assign done         = done_reg;
    assign result_index = res_idx_reg;
    assign result_value = res_val_reg;
    assign saturated    = sat_reg;
    assign bad_index    = bad_reg;

    // a good result only leaves through the final rounding step
    a_good_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        done && !bad_index |-> $past(state_reg == S_FIN))
        else $error("good result without final step");

    // a compute beat either starts the sequencer or answers at once
    a_compute_answers: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && operation |=> busy || done)
        else $error("compute beat dropped");

    // a bad index carries a zero value and no saturation
    a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && bad_index |-> result_value == '0 && !saturated)
        else $error("bad index result not clean");

    // the ram is only written while idle
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == S_IDLE)
        else $error("store write while busy");

endmodule

// ===== bench/tb_top.sv =====
// testbench for the grid laplacian stencil block: store fill, directed table, then randomized phases
module tb_top;
    import gls_pkg::*;

    localparam int DEPTH = DEF_MAX_POINTS;
    localparam int FILL = 256;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int DRAIN_CYCLES = 64;

    typedef struct {
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] val;
        logic                     sat;
        logic                     bad;
    } stencil_res_t;

    typedef struct {
        bit                       is_cfg;
        op_t                      op;
        logic [IDX_W-1:0]         idx;
        logic [CFG_IDX_W-1:0]     reg_sel;
        logic signed [DATA_W-1:0] el;
        logic signed [DATA_W-1:0] pt;
        bit                       typed;
        stencil_res_t             want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic operation;
    logic [IDX_W-1:0] index;
    logic signed [DATA_W-1:0] element;
    logic signed [DATA_W-1:0] potential_term;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DATA_W-1:0] cfg_data;
    logic done;
    logic [IDX_W-1:0] result_index;
    logic signed [DATA_W-1:0] result_value;
    logic saturated;
    logic bad_index;

    grid_laplacian_stencil_matvec dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .index(index), .element(element),
        .potential_term(potential_term), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .done(done), .result_index(result_index),
        .result_value(result_value), .saturated(saturated), .bad_index(bad_index)
    );

    // shadow of the block's registers and stores
    logic [DIMS_W-1:0]        g_dims;
    logic [SIZE_W-1:0]        g_sx, g_sy, g_sz;
    logic [DATA_W-1:0]        g_cx, g_cy, g_cz;
    logic signed [DATA_W-1:0] vec_mem [DEPTH];
    logic signed [DATA_W-1:0] pot_mem [DEPTH];
    bit                       wr_flag [DEPTH];

    stencil_res_t pending_results[$];
    stim_row_t    stim_table[$];
    int errors = 0;
    int n_results = 0;
    int n_sat = 0;
    int n_bad = 0;
    int n_beats = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #30_000_000;
        $display("tb: failure");
        $finish;
    end

    task automatic report(input string what);
        errors++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function automatic longint vec_at(input longint unsigned addr);
        if (addr >= DEPTH)
            return 0;
        return longint'(vec_mem[addr]);
    endfunction

    // 2v minus the in-grid neighbours along one axis
    function automatic longint axis_delta(input longint unsigned i, input longint v,
                                          input longint unsigned pos,
                                          input longint unsigned size,
                                          input longint unsigned stride);
        longint d;
        d = 2 * v;
        if (pos > 0)
            d -= vec_at(i - stride);
        if (pos + 1 < size)
            d -= vec_at(i + stride);
        return d;
    endfunction

    // neighbours along one axis that the block reads are all written
    function automatic bit nb_written(input longint unsigned i,
                                      input longint unsigned pos,
                                      input longint unsigned size,
                                      input longint unsigned stride);
        bit ok;
        ok = 1'b1;
        if (pos > 0 && i - stride < DEPTH)
            ok = ok && wr_flag[i - stride];
        if (pos + 1 < size && i + stride < DEPTH)
            ok = ok && wr_flag[i + stride];
        return ok;
    endfunction

    // every store entry a compute at idx would read has been written
    function automatic bit reads_written(input logic [IDX_W-1:0] idx);
        longint unsigned i, n, xpos, rest, ypos, zpos, sxy;
        int dims;
        bit ok;
        i = idx;
        n = longint'(g_sx) * longint'(g_sy) * longint'(g_sz);
        if (i >= n || i >= DEPTH)
            return 1'b1;
        dims = (g_dims == 0) ? 1 : int'(g_dims);
        xpos = i % g_sx;
        rest = i / g_sx;
        ypos = rest % g_sy;
        zpos = rest / g_sy;
        sxy = longint'(g_sx) * longint'(g_sy);
        ok = wr_flag[i] && nb_written(i, xpos, g_sx, 1);
        if (dims >= 2)
            ok = ok && nb_written(i, ypos, g_sy, g_sx);
        if (dims == 3)
            ok = ok && nb_written(i, zpos, g_sz, sxy);
        return ok;
    endfunction

    function automatic stencil_res_t apply_stencil(input logic [IDX_W-1:0] idx);
        stencil_res_t r;
        longint unsigned i, n, xpos, rest, ypos, zpos;
        longint v, p, hi, lo, d, sum;
        int dims;
        r.idx = idx;
        r.val = '0;
        r.sat = 1'b0;
        r.bad = 1'b0;
        i = idx;
        n = longint'(g_sx) * longint'(g_sy) * longint'(g_sz);
        dims = (g_dims == 0) ? 1 : int'(g_dims);
        if (i >= n || i >= DEPTH)
        begin
            r.bad = 1'b1;
            return r;
        end
        xpos = i % g_sx;
        rest = i / g_sx;
        ypos = rest % g_sy;
        zpos = rest / g_sy;
        v = longint'(vec_mem[i]);
        p = longint'(pot_mem[i]);
        hi = 0;
        lo = v * p;
        d = axis_delta(i, v, xpos, g_sx, 1);
        hi += d * longint'(g_cx[31:16]);
        lo += d * longint'(g_cx[15:0]);
        if (dims >= 2)
        begin
            d = axis_delta(i, v, ypos, g_sy, g_sx);
            hi += d * longint'(g_cy[31:16]);
            lo += d * longint'(g_cy[15:0]);
        end
        if (dims == 3)
        begin
            d = axis_delta(i, v, zpos, g_sz, longint'(g_sx) * longint'(g_sy));
            hi += d * longint'(g_cz[31:16]);
            lo += d * longint'(g_cz[15:0]);
        end
        // round to nearest, ties up: floor of (lo + half) / 2^16
        sum = hi + ((lo + 32768) >>> 16);
        if (sum > 64'sd2147483647)
        begin
            sum = 64'sd2147483647;
            r.sat = 1'b1;
        end
        else if (sum < -64'sd2147483648)
        begin
            sum = -64'sd2147483648;
            r.sat = 1'b1;
        end
        r.val = sum[DATA_W-1:0];
        return r;
    endfunction

    // result checker: done is a one-cycle strobe
    always @(posedge clk)
    begin
        stencil_res_t w;
        if (rst_n && done)
        begin
            n_results++;
            if (pending_results.size() == 0)
                report($sformatf("result beat idx %0d with nothing expected", result_index));
            else
            begin
                w = pending_results.pop_front();
                if (result_index !== w.idx)
                    report($sformatf("result_index %0d, want %0d", result_index, w.idx));
                if (result_value !== w.val)
                    report($sformatf("idx %0d result_value %h, want %h",
                                     w.idx, result_value, w.val));
                if (saturated !== w.sat)
                    report($sformatf("idx %0d saturated %b, want %b",
                                     w.idx, saturated, w.sat));
                if (bad_index !== w.bad)
                    report($sformatf("idx %0d bad_index %b, want %b",
                                     w.idx, bad_index, w.bad));
                n_sat += w.sat;
                n_bad += w.bad;
            end
        end
    end

    task automatic issue(input op_t op, input logic [IDX_W-1:0] idx,
                         input logic signed [DATA_W-1:0] el,
                         input logic signed [DATA_W-1:0] pt,
                         input bit typed, input stencil_res_t want, input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        operation <= op;
        index <= idx;
        element <= el;
        potential_term <= pt;
        do
            @(posedge clk);
        while (busy);
        n_beats++;
        if (op == OP_STORE)
        begin
            vec_mem[idx] = el;
            pot_mem[idx] = pt;
            wr_flag[idx] = 1'b1;
        end
        else if (typed)
            pending_results.push_back(want);
        else
            pending_results.push_back(apply_stencil(idx));
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        start <= 1'b0;
        while ((pending_results.size() != 0 || busy) && guard < 100_000)
        begin
            @(posedge clk);
            guard++;
        end
        if (guard >= 100_000)
        begin
            $display("tb: failure");
            $finish;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // leaves cfg_we high; caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= sel;
        cfg_data <= val;
        @(posedge clk);
        case (sel)
            CFG_DIMENSIONS: g_dims = val[DIMS_W-1:0];
            CFG_SIZE_X:     g_sx = val[SIZE_W-1:0];
            CFG_SIZE_Y:     g_sy = val[SIZE_W-1:0];
            CFG_SIZE_Z:     g_sz = val[SIZE_W-1:0];
            CFG_COEF_X:     g_cx = val;
            CFG_COEF_Y:     g_cy = val;
            CFG_COEF_Z:     g_cz = val;
            default: ;
        endcase
    endtask

    task automatic setup_grid(input int dims, input int sx, input int sy, input int sz,
                              input logic [DATA_W-1:0] cx, input logic [DATA_W-1:0] cy,
                              input logic [DATA_W-1:0] cz);
        write_reg(CFG_DIMENSIONS, dims);
        write_reg(CFG_SIZE_X, sx);
        write_reg(CFG_SIZE_Y, sy);
        write_reg(CFG_SIZE_Z, sz);
        write_reg(CFG_COEF_X, cx);
        write_reg(CFG_COEF_Y, cy);
        write_reg(CFG_COEF_Z, cz);
        // unused register index must be ignored
        write_reg(CFG_UNUSED, $urandom);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [DATA_W-1:0] pick_coef(input int mode);
        case (mode % 4)
            0: return $urandom;
            1: return $urandom_range(0, 32'h0003_ffff);
            2: return 32'hffff_ffff;
            default: return 32'h0;
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        if ($urandom_range(1))
            return $urandom;
        return $signed($urandom_range(0, 32'h0003_ffff)) - 32'sh0002_0000;
    endfunction

    task automatic add_item(input op_t op, input int idx, input logic [DATA_W-1:0] el,
                            input logic [DATA_W-1:0] pt, input bit typed,
                            input logic [DATA_W-1:0] val, input bit sat, input bit bad);
        stim_row_t r;
        r.is_cfg = 1'b0;
        r.op = op;
        r.idx = IDX_W'(idx);
        r.reg_sel = CFG_DIMENSIONS;
        r.el = el;
        r.pt = pt;
        r.typed = typed;
        r.want.idx = IDX_W'(idx);
        r.want.val = val;
        r.want.sat = sat;
        r.want.bad = bad;
        stim_table.push_back(r);
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] sel, input logic [DATA_W-1:0] val);
        stim_row_t r;
        r.is_cfg = 1'b1;
        r.op = OP_STORE;
        r.idx = '0;
        r.reg_sel = sel;
        r.el = val;
        r.pt = '0;
        r.typed = 1'b0;
        r.want = '{default: '0};
        stim_table.push_back(r);
    endtask

    initial
    begin
        int dims_tab [10] = '{1, 2, 3, 3, 0, 3, 2, 3, 3, 1};
        int sx_tab   [10] = '{4096, 64, 16, 8, 13, 0, 4095, 1, 2, 4096};
        int sy_tab   [10] = '{1, 64, 16, 8, 7, 4, 1, 1, 3, 4096};
        int sz_tab   [10] = '{1, 1, 16, 64, 5, 4, 1, 4096, 4, 4096};
        int idle_tab [4]  = '{0, 50, 13, 0};
        longint unsigned span;
        int lim;
        int k;
        op_t op;
        logic [IDX_W-1:0] ri;
        stencil_res_t nil;

        rst_n = 1'b0;
        start = 1'b0;
        operation = OP_STORE;
        index = '0;
        element = '0;
        potential_term = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_DIMENSIONS;
        cfg_data = '0;
        g_dims = DIMS_W'(1);
        g_sx = SIZE_W'(1);
        g_sy = SIZE_W'(1);
        g_sz = SIZE_W'(1);
        g_cx = '0;
        g_cy = '0;
        g_cz = '0;
        nil = '{default: '0};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the low part of both stores; later computes only read written entries
        for (int i = 0; i < FILL; i++)
            issue(OP_STORE, IDX_W'(i), pick_value(), pick_value(), 1'b0, nil, 0);

        // directed part, reset registers first: one point grid, zero coefficients
        add_item(OP_STORE, 0, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0, 0);
        add_item(OP_COMPUTE, 0, 0, 0, 1, 32'h7fff_ffff, 1, 0);
        add_item(OP_STORE, 0, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, 0);
        add_item(OP_COMPUTE, 0, 0, 0, 1, 32'h8000_0000, 1, 0);
        add_item(OP_STORE, 0, 32'h0001_0000, 32'h0001_0000, 0, 0, 0, 0);
        add_item(OP_COMPUTE, 0, 0, 0, 1, 32'h0001_0000, 0, 0);
        add_item(OP_COMPUTE, 1, 0, 0, 1, 0, 0, 1);
        add_item(OP_COMPUTE, 4095, 0, 0, 1, 0, 0, 1);
        add_item(OP_STORE, 4095, 32'hffff_ffff, 32'h8000_0000, 0, 0, 0, 0);
        add_item(OP_STORE, 0, 32'h0, 32'h0, 0, 0, 0, 0);
        add_item(OP_COMPUTE, 0, 0, 0, 1, 0, 0, 0);
        // 4x4x4 grid with all three axes
        add_cfg(CFG_DIMENSIONS, 3);
        add_cfg(CFG_SIZE_X, 4);
        add_cfg(CFG_SIZE_Y, 4);
        add_cfg(CFG_SIZE_Z, 4);
        add_cfg(CFG_COEF_X, 32'h0001_0000);
        add_cfg(CFG_COEF_Y, 32'h0002_0000);
        add_cfg(CFG_COEF_Z, 32'h0000_8000);
        add_item(OP_COMPUTE, 0, 0, 0, 0, 0, 0, 0);
        add_item(OP_COMPUTE, 21, 0, 0, 0, 0, 0, 0);
        add_item(OP_COMPUTE, 63, 0, 0, 0, 0, 0, 0);
        add_item(OP_COMPUTE, 3, 0, 0, 0, 0, 0, 0);
        add_item(OP_COMPUTE, 48, 0, 0, 0, 0, 0, 0);
        add_item(OP_COMPUTE, 64, 0, 0, 1, 0, 0, 1);
        add_item(OP_COMPUTE, 4095, 0, 0, 1, 0, 0, 1);

        foreach (stim_table[j])
        begin
            if (stim_table[j].is_cfg)
            begin
                if (j == 0 || !stim_table[j-1].is_cfg)
                    drain();
                write_reg(stim_table[j].reg_sel, stim_table[j].el);
                if (j + 1 >= stim_table.size() || !stim_table[j+1].is_cfg)
                begin
                    cfg_we <= 1'b0;
                    @(posedge clk);
                end
            end
            else
                issue(stim_table[j].op, stim_table[j].idx, stim_table[j].el,
                      stim_table[j].pt, stim_table[j].typed, stim_table[j].want, 0);
        end

        // random phases over a spread of grid shapes and coefficient ranges
        for (int ph = 0; ph < 10; ph++)
        begin
            drain();
            setup_grid(dims_tab[ph], sx_tab[ph], sy_tab[ph], sz_tab[ph],
                       pick_coef(ph), pick_coef(ph + 1), pick_coef(ph + 2));
            span = longint'(g_sx) * longint'(g_sy) * longint'(g_sz);
            lim = (span == 0) ? 0 : ((span > FILL) ? FILL - 1 : int'(span - 1));
            k = (span == 0) ? 20 : 150;
            for (int n = 0; n < k; n++)
            begin
                op = ($urandom_range(99) < 30) ? OP_STORE : OP_COMPUTE;
                // mostly in the filled part of the grid, some anywhere in the 12-bit range
                if ($urandom_range(9) == 0)
                    ri = IDX_W'($urandom);
                else
                    ri = IDX_W'($urandom_range(0, lim));
                // a compute that would read a never-written entry stores there instead
                if (op == OP_COMPUTE && !reads_written(ri))
                    op = OP_STORE;
                issue(op, ri, pick_value(), pick_value(), 1'b0, nil, idle_tab[ph % 4]);
            end
        end

        drain();
        $display("covered %0d accepted beats, %0d results (%0d saturated, %0d bad index)",
                 n_beats, n_results, n_sat, n_bad);
        $display("grid shapes from 1 to 3 axes, sizes 0 to 4096, %0d mismatches", errors);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
